>>> rtl/opg_pkg.sv
// Shared types and constants for the overload pressure governor.
`timescale 1ns / 1ps

package opg_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned MaskWidth     = 7;
   localparam int unsigned LevelWidth    = 2;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SIM_TICK_LIMIT     = 3'd0,
      CSR_RENDER_LIMIT       = 3'd1,
      CSR_DERIVED_TIME_LIMIT = 3'd2,
      CSR_DERIVED_IO_LIMIT   = 3'd3,
      CSR_DERIVED_JOBS_LIMIT = 3'd4,
      CSR_CHUNK_LIMIT        = 3'd5,
      CSR_BUBBLE_LIMIT       = 3'd6
   } csr_index_type;

   // overrun mask bit positions
   localparam int unsigned MaskSim     = 0;
   localparam int unsigned MaskRender  = 1;
   localparam int unsigned MaskDerTime = 2;
   localparam int unsigned MaskDerIo   = 3;
   localparam int unsigned MaskDerJobs = 4;
   localparam int unsigned MaskChunks  = 5;
   localparam int unsigned MaskBubbles = 6;

   localparam logic [LevelWidth-1:0] PressureMin = 2'd0;
   localparam logic [LevelWidth-1:0] PressureMax = 2'd3;

   typedef struct packed {
      logic [15:0] sim_tick_limit_ms;
      logic [15:0] render_limit_ms;
      logic [15:0] derived_time_limit_ms;
      logic [31:0] derived_io_limit_bytes;
      logic [15:0] derived_jobs_limit;
      logic [15:0] chunk_limit;
      logic [7:0]  bubble_limit;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      sim_tick_limit_ms:      16'd12,
      render_limit_ms:        16'd8,
      derived_time_limit_ms:  16'd2,
      derived_io_limit_bytes: 32'd262144,
      derived_jobs_limit:     16'd4,
      chunk_limit:            16'd256,
      bubble_limit:           8'd1
   };

   typedef struct packed {
      logic        frame_valid;
      logic [31:0] sim_tick_us;
      logic [31:0] render_submit_us;
      logic        derived_valid;
      logic [15:0] derived_time_ms;
      logic [31:0] derived_io_bytes;
      logic [15:0] derived_jobs;
      logic [7:0]  bubble_count;
      logic [15:0] active_chunks;
   } meas_type;

   typedef struct packed {
      logic [MaskWidth-1:0]  overrun_mask;
      logic [LevelWidth-1:0] pressure_level;
      logic [15:0]           budget_time_ms;
      logic [31:0]           budget_io_bytes;
      logic [15:0]           budget_jobs;
   } result_type;

endpackage

>>> rtl/opg_eval.sv
// Limit checks, pressure step and budget scaling for one frame.
`timescale 1ns / 1ps

module opg_eval import opg_pkg::*; (
   input  cfg_type               cfg,
   input  meas_type              meas,
   input  logic [LevelWidth-1:0] pressure,
   output result_type            result
);

   // floor(base * {1, 3/4, 1/2, 1/4}), nonzero base never below 1
   function automatic logic [31:0] level_scale(input logic [31:0] base,
                                               input logic [LevelWidth-1:0] level);
      logic [33:0] triple;
      logic [31:0] r;
      triple = {2'b00, base} + {1'b0, base, 1'b0};
      case (level)
         2'd0:    r = base;
         2'd1:    r = triple[33:2];
         2'd2:    r = {1'b0, base[31:1]};
         default: r = {2'b00, base[31:2]};
      endcase
      if (base != 32'd0 && r == 32'd0) begin
         r = 32'd1;
      end
      return r;
   endfunction

   logic [25:0]           sim_limit_us;
   logic [25:0]           render_limit_us;
   logic [MaskWidth-1:0]  mask;
   logic [LevelWidth-1:0] level_next;
   logic [31:0]           time_scaled;
   logic [31:0]           io_scaled;
   logic [31:0]           jobs_scaled;

   // ms to us: constant multiply, 16 x 1000 fits in 26 bits
   assign sim_limit_us    = {10'd0, cfg.sim_tick_limit_ms} * 26'd1000;
   assign render_limit_us = {10'd0, cfg.render_limit_ms} * 26'd1000;

   always_comb begin
      mask = '0;
      mask[MaskSim] = meas.frame_valid && (cfg.sim_tick_limit_ms != 16'd0)
                      && (meas.sim_tick_us > {6'd0, sim_limit_us});
      mask[MaskRender] = meas.frame_valid && (cfg.render_limit_ms != 16'd0)
                         && (meas.render_submit_us > {6'd0, render_limit_us});
      mask[MaskDerTime] = meas.derived_valid && (cfg.derived_time_limit_ms != 16'd0)
                          && (meas.derived_time_ms > cfg.derived_time_limit_ms);
      mask[MaskDerIo] = meas.derived_valid && (cfg.derived_io_limit_bytes != 32'd0)
                        && (meas.derived_io_bytes > cfg.derived_io_limit_bytes);
      mask[MaskDerJobs] = meas.derived_valid && (cfg.derived_jobs_limit != 16'd0)
                          && (meas.derived_jobs > cfg.derived_jobs_limit);
      mask[MaskChunks] = (cfg.chunk_limit != 16'd0)
                         && (meas.active_chunks > cfg.chunk_limit);
      mask[MaskBubbles] = (cfg.bubble_limit != 8'd0)
                          && (meas.bubble_count > cfg.bubble_limit);
   end

   // saturating step: up on any overrun, down otherwise
   always_comb begin
      level_next = pressure;
      if (mask != '0) begin
         if (pressure != PressureMax) begin
            level_next = pressure + 2'd1;
         end
      end else if (pressure != PressureMin) begin
         level_next = pressure - 2'd1;
      end
   end

   assign time_scaled = level_scale({16'd0, cfg.derived_time_limit_ms}, level_next);
   assign io_scaled   = level_scale(cfg.derived_io_limit_bytes, level_next);
   assign jobs_scaled = level_scale({16'd0, cfg.derived_jobs_limit}, level_next);

   assign result.overrun_mask    = mask;
   assign result.pressure_level  = level_next;
   assign result.budget_time_ms  = time_scaled[15:0];
   assign result.budget_io_bytes = io_scaled;
   assign result.budget_jobs     = jobs_scaled[15:0];

endmodule

>>> rtl/overload_pressure_governor.sv
// Top level of the overload pressure governor: registers, handshake and CSRs.
`timescale 1ns / 1ps

// Each req transaction carries one frame's measurements; the block checks them
// against seven limits (a limit of zero turns its check off), builds a 7-bit
// overrun mask, steps a saturating pressure level 0..3 up on any overrun and
// down otherwise, and returns one rsp transaction with the mask, the new
// pressure, a fidelity level equal to it, and the time, byte and job budgets
// scaled by 1, 3/4, 1/2 or 1/4 (floor, never below 1 unless the base is 0).
// Throughput is one transaction per cycle while rsp_ready keeps up. Each
// frame sits in an input register, passes one layer of compare and scale
// logic, and lands in the result register, which drives rsp_valid. req_ready
// drops only while both registers are full and rsp_ready is low. Pressure
// updates as each frame enters the result register, so frames are applied
// strictly in arrival order. Write CSRs only while no transaction is in
// flight; indexes above six are dropped.
module overload_pressure_governor import opg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_frame_valid,
   input  logic [31:0]              req_sim_tick_us,
   input  logic [31:0]              req_render_submit_us,
   input  logic                     req_derived_valid,
   input  logic [15:0]              req_derived_time_ms,
   input  logic [31:0]              req_derived_io_bytes,
   input  logic [15:0]              req_derived_jobs,
   input  logic [7:0]               req_bubble_count,
   input  logic [15:0]              req_active_chunks,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MaskWidth-1:0]     rsp_overrun_mask,
   output logic [LevelWidth-1:0]    rsp_pressure_level,
   output logic [LevelWidth-1:0]    rsp_fidelity_level,
   output logic [15:0]              rsp_budget_time_ms,
   output logic [31:0]              rsp_budget_io_bytes,
   output logic [15:0]              rsp_budget_jobs
);

   cfg_type               cfg_ff, cfg_in;
   meas_type              meas_ff, meas_in;
   logic                  meas_valid_ff, meas_valid_in;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LevelWidth-1:0] pressure_ff, pressure_in;
   result_type            eval_result;
   logic                  advance;
   logic                  req_fire;

   // ---------------------------------------------------------------------
   // CSR writes
   // ---------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIM_TICK_LIMIT:     cfg_in.sim_tick_limit_ms      = csr_wdata[15:0];
            CSR_RENDER_LIMIT:       cfg_in.render_limit_ms        = csr_wdata[15:0];
            CSR_DERIVED_TIME_LIMIT: cfg_in.derived_time_limit_ms  = csr_wdata[15:0];
            CSR_DERIVED_IO_LIMIT:   cfg_in.derived_io_limit_bytes = csr_wdata;
            CSR_DERIVED_JOBS_LIMIT: cfg_in.derived_jobs_limit     = csr_wdata[15:0];
            CSR_CHUNK_LIMIT:        cfg_in.chunk_limit            = csr_wdata[15:0];
            CSR_BUBBLE_LIMIT:       cfg_in.bubble_limit           = csr_wdata[7:0];
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: the result register advances when empty or being drained;
   // the input register refills whenever its contents move on.
   // ---------------------------------------------------------------------
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !meas_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      meas_in = meas_ff;
      if (req_fire) begin
         meas_in.frame_valid      = req_frame_valid;
         meas_in.sim_tick_us      = req_sim_tick_us;
         meas_in.render_submit_us = req_render_submit_us;
         meas_in.derived_valid    = req_derived_valid;
         meas_in.derived_time_ms  = req_derived_time_ms;
         meas_in.derived_io_bytes = req_derived_io_bytes;
         meas_in.derived_jobs     = req_derived_jobs;
         meas_in.bubble_count     = req_bubble_count;
         meas_in.active_chunks    = req_active_chunks;
      end
   end

   assign meas_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : meas_valid_ff);

   opg_eval u_eval (
      .cfg      (cfg_ff),
      .meas     (meas_ff),
      .pressure (pressure_ff),
      .result   (eval_result)
   );

   // load the result register and commit pressure together
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      pressure_in  = pressure_ff;
      if (advance) begin
         rsp_valid_in = meas_valid_ff;
         if (meas_valid_ff) begin
            rsp_in      = eval_result;
            pressure_in = eval_result.pressure_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CfgReset;
         meas_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pressure_ff   <= PressureMin;
      end else begin
         cfg_ff        <= cfg_in;
         meas_valid_ff <= meas_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pressure_ff   <= pressure_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      meas_ff <= meas_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_overrun_mask    = rsp_ff.overrun_mask;
   assign rsp_pressure_level  = rsp_ff.pressure_level;
   assign rsp_fidelity_level  = rsp_ff.pressure_level;
   assign rsp_budget_time_ms  = rsp_ff.budget_time_ms;
   assign rsp_budget_io_bytes = rsp_ff.budget_io_bytes;
   assign rsp_budget_jobs     = rsp_ff.budget_jobs;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // a pending result always reports the committed pressure
   a_rsp_matches_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.pressure_level == pressure_ff))
      else $error("result pressure differs from committed pressure");

   // pressure never steps down on an overrun, nor up without one
   a_pressure_direction: assert property (@(posedge clock) disable iff (reset)
      (advance && meas_valid_ff) |=>
         (((rsp_ff.overrun_mask != '0) && (pressure_ff >= $past(pressure_ff))) ||
          ((rsp_ff.overrun_mask == '0) && (pressure_ff <= $past(pressure_ff)))))
      else $error("pressure stepped the wrong way");

   // a stalled frame stays in the input register
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (meas_valid_ff && !advance) |=> meas_valid_ff)
      else $error("stalled frame lost from input register");

endmodule
